@@ hw/rtl/assert_macros.svh @@
// ------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands for the projection core. They assume a
// clock named clk and an active-low reset named rst_n in scope.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/ppm_pkg.sv @@
// ------------------------------------------------------------------------
// Projection matrix package
// Widths, register indexes, pipeline types and the CORDIC angle table.
// ------------------------------------------------------------------------
package ppm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int DIV_STEPS    = 32;
    localparam int LANES        = 4;
    localparam int STAGES       = CORDIC_STEPS + DIV_STEPS + 4;

    localparam int NUM_W  = 65 + FRAC_BITS;
    localparam int HI_W   = NUM_W - DIV_STEPS;
    localparam int LANE_W = (HI_W > 56) ? HI_W : 56;
    localparam int ANG_W  = 33;

    localparam int IN_W  = 104;
    localparam int OUT_W = 136;
    localparam int USR_W = 2;

    localparam logic [14:0] FOV_MAX = 15'd25735;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_HANDED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_RANGE  = 2'd1;

    localparam logic [1:0] W_SIGN_RH = 2'b11;
    localparam logic [1:0] W_SIGN_LH = 2'b01;

    localparam int LANE_M00 = 0;
    localparam int LANE_M11 = 1;
    localparam int LANE_M22 = 2;
    localparam int LANE_M32 = 3;

    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } ppm_rot_t;

    typedef struct packed {
        logic [23:0] aspect;
        logic [31:0] span;
        logic [32:0] num;
        logic [63:0] fn;
        logic        rh;
        logic        no;
        logic        neg22;
        logic        neg32;
        logic        inv;
    } ppm_side_t;

    typedef struct packed {
        logic rh;
        logic neg22;
        logic neg32;
        logic inv;
    } ppm_flags_t;

    typedef struct packed {
        logic [LANE_W-1:0] rem;
        logic [LANE_W-1:0] den;
        logic [31:0]       lo;
        logic [31:0]       q;
        logic              big;
    } ppm_div_t;

    // Truncated atan(2^-i) in Q2.30.
    function automatic logic [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 33'h03243F6A8;
            5'd1:    v = 33'h01DAC6705;
            5'd2:    v = 33'h00FADBAFC;
            5'd3:    v = 33'h007F56EA6;
            5'd4:    v = 33'h003FEAB76;
            5'd5:    v = 33'h001FFD55B;
            5'd6:    v = 33'h000FFFAAA;
            5'd7:    v = 33'h0007FFF55;
            5'd8:    v = 33'h0003FFFEA;
            5'd9:    v = 33'h0001FFFFD;
            5'd10:   v = 33'h0000FFFFF;
            5'd11:   v = 33'h00007FFFF;
            5'd12:   v = 33'h00003FFFF;
            5'd13:   v = 33'h00001FFFF;
            5'd14:   v = 33'h00000FFFF;
            5'd15:   v = 33'h000007FFF;
            5'd16:   v = 33'h000003FFF;
            5'd17:   v = 33'h000001FFF;
            5'd18:   v = 33'h000000FFF;
            5'd19:   v = 33'h0000007FF;
            5'd20:   v = 33'h0000003FF;
            5'd21:   v = 33'h0000001FF;
            5'd22:   v = 33'h0000000FF;
            5'd23:   v = 33'h00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/ppm_cordic_cell.sv @@
// ------------------------------------------------------------------------
// CORDIC cell
// One registered rotation step; passes the item's side data along.
// ------------------------------------------------------------------------
module ppm_cordic_cell (
    input  logic                      clk,
    input  logic                      en,
    input  logic [ppm_pkg::STEP_W-1:0] step,
    input  ppm_pkg::ppm_rot_t         rot_in,
    input  ppm_pkg::ppm_side_t        side_in,
    output ppm_pkg::ppm_rot_t         rot_out,
    output ppm_pkg::ppm_side_t        side_out
);
    import ppm_pkg::*;

    ppm_rot_t                rot_reg;
    ppm_rot_t                rot_next;
    ppm_side_t               side_reg;
    logic signed [ANG_W-1:0] dx;
    logic signed [ANG_W-1:0] dy;
    logic signed [ANG_W-1:0] ang;

    always_comb
    begin
        dx  = rot_in.y >>> step;
        dy  = rot_in.x >>> step;
        ang = signed'(atan_step(step));
        if (!rot_in.z[ANG_W-1])
        begin
            rot_next.x = rot_in.x - dx;
            rot_next.y = rot_in.y + dy;
            rot_next.z = rot_in.z - ang;
        end
        else
        begin
            rot_next.x = rot_in.x + dx;
            rot_next.y = rot_in.y - dy;
            rot_next.z = rot_in.z + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg  <= rot_next;
            side_reg <= side_in;
        end
    end

    assign rot_out  = rot_reg;
    assign side_out = side_reg;

endmodule

@@ hw/rtl/ppm_div_cell.sv @@
// ------------------------------------------------------------------------
// Divider cell
// One registered restoring-division step producing one quotient bit.
// ------------------------------------------------------------------------
module ppm_div_cell (
    input  logic              clk,
    input  logic              en,
    input  ppm_pkg::ppm_div_t div_in,
    output ppm_pkg::ppm_div_t div_out
);
    import ppm_pkg::*;

    ppm_div_t          div_reg;
    ppm_div_t          div_next;
    logic [LANE_W:0]   trial;
    logic [LANE_W:0]   diff;
    logic              ge;

    always_comb
    begin
        trial        = {div_in.rem, div_in.lo[31]};
        diff         = trial - {1'b0, div_in.den};
        ge           = trial >= {1'b0, div_in.den};
        div_next     = div_in;
        div_next.rem = ge ? diff[LANE_W-1:0] : trial[LANE_W-1:0];
        div_next.lo  = {div_in.lo[30:0], 1'b0};
        div_next.q   = {div_in.q[30:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

@@ hw/rtl/perspective_projection_matrix_core.sv @@
// ------------------------------------------------------------------------
// Perspective projection matrix core
// Throughput: one item per cycle; a stall on the output freezes all stages.
// An accepted item passes through the input stage, 24 CORDIC cells, two set-up
// stages, 32 divider cells per lane and the output register.
// Reset clears the valid bits and sets right-handed, 0..1 depth range.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module perspective_projection_matrix_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: fov_angle[14:0], aspect_ratio[38:15], near_dist[70:39],
    // far_dist[102:71], zero pad [103].
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ppm_pkg::IN_W-1:0]      s_tdata,
    // m_tdata: x_scale[31:0], y_scale[63:32], depth_scale[95:64],
    // w_sign[97:96], depth_offset[129:98], zero pad [135:130].
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ppm_pkg::OUT_W-1:0]     m_tdata,
    // m_tuser: saturated[0], invalid[1].
    output logic [ppm_pkg::USR_W-1:0]     m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_data
);
    import ppm_pkg::*;

    // The whole pipeline moves together whenever the output register can
    // take a new item, so an item enters in every cycle without a stall.
    logic adv;
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    logic rh_reg;
    logic no_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rh_reg <= 1'b1;
            no_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RIGHT_HANDED: rh_reg <= cfg_data;
                REG_DEPTH_RANGE:  no_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // One valid bit per pipeline stage.
    logic [STAGES-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], s_tvalid};
        end
    end

    assign m_tvalid = vld_reg[STAGES-1];

    // Input stage: unpack, clamp the angle, work out the depth terms and
    // the product f*n, and seed the rotation.
    logic [14:0] in_fov;
    logic [23:0] in_aspect;
    logic [31:0] in_near;
    logic [31:0] in_far;
    logic [14:0] fov_clamped;
    ppm_side_t   s0_side_next;
    ppm_rot_t    s0_rot_next;
    ppm_side_t   s0_side_reg;
    ppm_rot_t    s0_rot_reg;

    assign in_fov    = s_tdata[14:0];
    assign in_aspect = s_tdata[38:15];
    assign in_near   = s_tdata[70:39];
    assign in_far    = s_tdata[102:71];

    always_comb
    begin
        fov_clamped         = (in_fov > FOV_MAX) ? FOV_MAX : in_fov;
        s0_rot_next.x       = ANG_W'(33'd1 << 30);
        s0_rot_next.y       = '0;
        s0_rot_next.z       = signed'({2'b00, fov_clamped, 16'h0000});
        s0_side_next.aspect = in_aspect;
        s0_side_next.span   = (in_far > in_near) ? (in_far - in_near) : (in_near - in_far);
        s0_side_next.num    = no_reg ? ({1'b0, in_far} + {1'b0, in_near}) : {1'b0, in_far};
        s0_side_next.fn     = 64'(in_far) * 64'(in_near);
        s0_side_next.rh     = rh_reg;
        s0_side_next.no     = no_reg;
        s0_side_next.neg22  = rh_reg != (in_far < in_near);
        s0_side_next.neg32  = in_far > in_near;
        s0_side_next.inv    = (in_fov == '0) || (in_aspect == '0) || (in_near == in_far);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_rot_reg  <= s0_rot_next;
            s0_side_reg <= s0_side_next;
        end
    end

    // Chain of CORDIC cells, one rotation step each.
    ppm_rot_t  rot_chain  [CORDIC_STEPS+1];
    ppm_side_t side_chain [CORDIC_STEPS+1];

    assign rot_chain[0]  = s0_rot_reg;
    assign side_chain[0] = s0_side_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        ppm_cordic_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .step     (STEP_W'(g)),
            .rot_in   (rot_chain[g]),
            .side_in  (side_chain[g]),
            .rot_out  (rot_chain[g+1]),
            .side_out (side_chain[g+1])
        );
    end

    // Post-rotation stage: clamp the vector and form aspect * y, the
    // divisor of the horizontal scale.
    ppm_rot_t    rot_end;
    logic [30:0] ux_next;
    logic [30:0] uy_next;
    logic [30:0] ux_reg;
    logic [30:0] uy_reg;
    logic [54:0] prod_reg;
    ppm_side_t   p1_side_reg;

    assign rot_end = rot_chain[CORDIC_STEPS];

    always_comb
    begin
        ux_next = rot_end.x[ANG_W-1] ? '0 : rot_end.x[30:0];
        uy_next = (rot_end.y < 1) ? 31'd1 : rot_end.y[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ux_reg      <= ux_next;
            uy_reg      <= uy_next;
            prod_reg    <= 55'(side_chain[CORDIC_STEPS].aspect) * 55'(uy_next);
            p1_side_reg <= side_chain[CORDIC_STEPS];
        end
    end

    // Divider set-up: the numerator of each lane is shifted into place,
    // its upper part becomes the starting remainder, and a quotient that
    // would not fit in 32 bits is flagged at once.
    logic [NUM_W-1:0]  lane_num  [LANES];
    logic [LANE_W-1:0] lane_den  [LANES];
    ppm_div_t          d0_next   [LANES];
    ppm_div_t          d0_reg    [LANES];
    ppm_flags_t        flags_reg [DIV_STEPS+1];

    always_comb
    begin
        lane_num[LANE_M00] = NUM_W'(ux_reg) << (FRAC_BITS + 16);
        lane_den[LANE_M00] = LANE_W'(prod_reg);
        lane_num[LANE_M11] = NUM_W'(ux_reg) << FRAC_BITS;
        lane_den[LANE_M11] = LANE_W'(uy_reg);
        lane_num[LANE_M22] = NUM_W'(p1_side_reg.num) << FRAC_BITS;
        lane_den[LANE_M22] = LANE_W'(p1_side_reg.span);
        lane_num[LANE_M32] = NUM_W'(p1_side_reg.fn) << (FRAC_BITS + int'(p1_side_reg.no));
        lane_den[LANE_M32] = LANE_W'(p1_side_reg.span) << 16;
        for (int k = 0; k < LANES; k++)
        begin
            d0_next[k].big = LANE_W'(lane_num[k][NUM_W-1:DIV_STEPS]) >= lane_den[k];
            d0_next[k].rem = d0_next[k].big ? '0 : LANE_W'(lane_num[k][NUM_W-1:DIV_STEPS]);
            d0_next[k].den = lane_den[k];
            d0_next[k].lo  = lane_num[k][DIV_STEPS-1:0];
            d0_next[k].q   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                d0_reg[k] <= d0_next[k];
            end
            flags_reg[0].rh    <= p1_side_reg.rh;
            flags_reg[0].neg22 <= p1_side_reg.neg22;
            flags_reg[0].neg32 <= p1_side_reg.neg32;
            flags_reg[0].inv   <= p1_side_reg.inv;
            for (int j = 1; j <= DIV_STEPS; j++)
            begin
                flags_reg[j] <= flags_reg[j-1];
            end
        end
    end

    // Four lanes of divider cells, one quotient bit per cell.
    ppm_div_t div_chain [LANES][DIV_STEPS+1];

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        assign div_chain[k][0] = d0_reg[k];
        for (genvar j = 0; j < DIV_STEPS; j++)
        begin : g_step
            ppm_div_cell u_cell (
                .clk     (clk),
                .en      (adv),
                .div_in  (div_chain[k][j]),
                .div_out (div_chain[k][j+1])
            );
        end
    end

    // Output stage: saturate each quotient, apply signs and pack, or send zeros for an invalid item.
    ppm_flags_t        fl;
    logic              lane_neg [LANES];
    logic [31:0]       lane_lim [LANES];
    logic              lane_ov  [LANES];
    logic [31:0]       lane_val [LANES];
    logic              any_ov;
    logic [OUT_W-1:0]  data_next;
    logic [USR_W-1:0]  user_next;
    logic [OUT_W-1:0]  data_reg;
    logic [USR_W-1:0]  user_reg;

    assign fl = flags_reg[DIV_STEPS];

    always_comb
    begin
        lane_neg[LANE_M00] = 1'b0;
        lane_neg[LANE_M11] = 1'b0;
        lane_neg[LANE_M22] = fl.neg22;
        lane_neg[LANE_M32] = fl.neg32;
        any_ov = 1'b0;
        for (int k = 0; k < LANES; k++)
        begin
            lane_lim[k] = lane_neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            lane_ov[k]  = div_chain[k][DIV_STEPS].big || (div_chain[k][DIV_STEPS].q > lane_lim[k]);
            lane_val[k] = lane_ov[k] ? lane_lim[k] : div_chain[k][DIV_STEPS].q;
            lane_val[k] = lane_neg[k] ? (32'h0 - lane_val[k]) : lane_val[k];
            any_ov      = any_ov || lane_ov[k];
        end
        if (fl.inv)
        begin
            data_next = '0;
            user_next = 2'b10;
        end
        else
        begin
            data_next = {6'b000000, lane_val[LANE_M32], fl.rh ? W_SIGN_RH : W_SIGN_LH,
                         lane_val[LANE_M22], lane_val[LANE_M11], lane_val[LANE_M00]};
            user_next = {1'b0, any_ov};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign m_tdata = data_reg;
    assign m_tuser = user_reg;

    // An invalid item carries all-zero entries and no saturation.
    `ASSERT_HOLDS(a_invalid_zero, !(m_tvalid && m_tuser[1]) || ((m_tdata == '0) && !m_tuser[0]))
    // Both scale entries are quotients of non-negative terms.
    `ASSERT_HOLDS(a_scale_positive, !m_tvalid || (!m_tdata[31] && !m_tdata[63]))
    // A valid item that is not flagged invalid carries a w sign of plus or minus one.
    `ASSERT_HOLDS(a_wsign_coded, !m_tvalid || m_tuser[1] || (m_tdata[97:96] == W_SIGN_RH) || (m_tdata[97:96] == W_SIGN_LH))
    // A stalled output freezes every stage of the pipeline.
    `ASSERT_NEXT(a_stall_freeze, m_tvalid && !m_tready, vld_reg == $past(vld_reg))

endmodule
